// ===== rtl/stft_pkg.sv =====
// Shared types, constants and twiddle function for the windowed STFT stream.
// No dependencies.
package stft_pkg;

    localparam int FFT_LEN_DEF      = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int RING_DEPTH       = 64;
    localparam int RING_AW          = 6;
    localparam int BIN_W            = 22;
    localparam int WLEN_RESET       = 64;
    localparam int HOP_RESET        = 16;
    localparam int CFG_W            = 16;

    localparam logic CFG_WLEN = 1'b0;
    localparam logic CFG_HOP  = 1'b1;

    // Frame job handed from the front part to the transform engine
    typedef struct packed {
        logic [RING_AW-1:0] start;
        logic [6:0]         wlen;
        logic [15:0]        frame;
    } t_job;

    // Q3.15 cosine over a 64-step circle, 18-bit signed
    function automatic logic signed [17:0] cos64(input logic [5:0] m);
        logic [4:0] q;
        logic signed [17:0] v;
        logic [5:0] a;
        q = 5'd0;
        v = 18'sd0;
        if (m <= 6'd16) begin
            a = m; v = 18'sd0;
        end else if (m <= 6'd32) begin
            a = 6'd32 - m;
        end else if (m <= 6'd48) begin
            a = m - 6'd32;
        end else begin
            a = 6'd0 - m;
        end
        q = a[4:0];
        case (q)
            5'd0:  v = 18'sd32768;
            5'd1:  v = 18'sd32610;
            5'd2:  v = 18'sd32138;
            5'd3:  v = 18'sd31357;
            5'd4:  v = 18'sd30274;
            5'd5:  v = 18'sd28899;
            5'd6:  v = 18'sd27246;
            5'd7:  v = 18'sd25330;
            5'd8:  v = 18'sd23170;
            5'd9:  v = 18'sd20788;
            5'd10: v = 18'sd18205;
            5'd11: v = 18'sd15447;
            5'd12: v = 18'sd12540;
            5'd13: v = 18'sd9512;
            5'd14: v = 18'sd6393;
            5'd15: v = 18'sd3212;
            default: v = 18'sd0;
        endcase
        if (m > 6'd16 && m <= 6'd48) v = -v;
        return v;
    endfunction

endpackage

// ===== rtl/stft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/stft_front.sv =====
// Front part: accepts items, writes the window table and sample ring, tracks framing.
// Depends on stft_pkg and stft_ram.
module stft_front #(
    parameter int FFT_LEN      = stft_pkg::FFT_LEN_DEF,
    parameter int SAMPLE_WIDTH = stft_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_func,
    input  logic [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic                     i_restart,
    input  logic [5:0]               i_coef_index,
    input  logic [15:0]              i_coef_value,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic                     i_cfg_valid,
    input  logic [stft_pkg::CFG_W-1:0] i_cfg_data,
    // job hand-off
    output logic                     o_job_valid,
    output stft_pkg::t_job           o_job,
    input  logic                     i_job_ready,
    input  logic                     i_eng_loading,
    // engine read ports
    input  logic [5:0]               i_ring_raddr,
    output logic [SAMPLE_WIDTH-1:0]  o_ring_rdata,
    input  logic [5:0]               i_win_raddr,
    output logic [15:0]              o_win_rdata
);
    logic [6:0]  r_wlen;
    logic [15:0] r_hop;
    logic [31:0] r_seen, r_end;
    logic [15:0] r_frame;
    logic        r_job_valid;
    stft_pkg::t_job r_job;

    logic [6:0]  eff_wlen, cfg_wlen;
    logic [31:0] seen_c, end_c;
    logic [15:0] frame_c, hop_eff;
    logic        take, smp, hit;

    // Effective window length clamp
    function automatic logic [6:0] clamp_wl(input logic [6:0] w);
        logic [6:0] r;
        r = w;
        if (w == 7'd0) r = 7'd1;
        if (w > 7'(FFT_LEN)) r = 7'(FFT_LEN);
        return r;
    endfunction

    assign eff_wlen = clamp_wl(r_wlen);
    assign cfg_wlen = clamp_wl(i_cfg_data[6:0]);
    // Hold off while a frame job waits or the engine copies the frame out of ring and table
    assign o_full = r_job_valid || i_eng_loading;
    assign take   = i_push && !o_full;
    assign smp    = take && !i_func;
    assign hop_eff = (r_hop == 16'd0) ? 16'd1 : r_hop;

    always_comb begin
        seen_c  = r_seen;
        end_c   = r_end;
        frame_c = r_frame;
        if (i_restart) begin
            seen_c  = 32'd0;
            end_c   = 32'(eff_wlen) - 32'd1;
            frame_c = 16'd0;
        end
    end
    assign hit = (seen_c == end_c);

    // Framing counters and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= 7'(stft_pkg::WLEN_RESET);
            r_hop       <= 16'(stft_pkg::HOP_RESET);
            r_seen      <= 32'd0;
            r_end       <= 32'(stft_pkg::WLEN_RESET) - 32'd1;
            r_frame     <= 16'd0;
            r_job_valid <= 1'b0;
        end else begin
            if (r_job_valid && i_job_ready) r_job_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_valid) begin
                    r_seen  <= 32'd0;
                    r_frame <= 16'd0;
                    if (i_cfg_index == stft_pkg::CFG_WLEN) begin
                        r_wlen <= i_cfg_data[6:0];
                        r_end  <= 32'(cfg_wlen) - 32'd1;
                    end else begin
                        r_hop <= i_cfg_data;
                        r_end <= 32'(eff_wlen) - 32'd1;
                    end
                end
            end else if (smp) begin
                r_seen <= seen_c + 32'd1;
                r_end  <= end_c;
                r_frame <= frame_c;
                if (hit) begin
                    r_end       <= end_c + 32'(hop_eff);
                    r_frame     <= frame_c + 16'd1;
                    r_job_valid <= 1'b1;
                end
            end
        end
    end

    // Job payload
    always_ff @(posedge i_clk) begin
        if (smp && hit) begin
            r_job.start <= 6'(seen_c - (32'(eff_wlen) - 32'd1));
            r_job.wlen  <= eff_wlen;
            r_job.frame <= frame_c;
        end
    end
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    stft_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(stft_pkg::RING_DEPTH)) u_ring (
        .i_clk(i_clk), .i_we(smp), .i_waddr(seen_c[5:0]), .i_wdata(i_sample),
        .i_raddr(i_ring_raddr), .o_rdata(o_ring_rdata)
    );
    stft_ram #(.WIDTH(16), .DEPTH(stft_pkg::RING_DEPTH)) u_win (
        .i_clk(i_clk), .i_we(take && i_func), .i_waddr(i_coef_index),
        .i_wdata(i_coef_value), .i_raddr(i_win_raddr), .o_rdata(o_win_rdata)
    );
endmodule

// ===== rtl/stft_engine.sv =====
// Back part: windows the frame into a buffer, then runs one MAC per cycle per bin.
// Depends on stft_pkg and stft_ram.
module stft_engine #(
    parameter int FFT_LEN      = stft_pkg::FFT_LEN_DEF,
    parameter int SAMPLE_WIDTH = stft_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_valid,
    input  stft_pkg::t_job           i_job,
    output logic                     o_job_ready,
    output logic                     o_loading,
    output logic [5:0]               o_ring_raddr,
    input  logic [SAMPLE_WIDTH-1:0]  i_ring_rdata,
    output logic [5:0]               o_win_raddr,
    input  logic [15:0]              i_win_rdata,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [15:0]              o_frame_number,
    output logic [5:0]               o_bin_index,
    output logic [stft_pkg::BIN_W-1:0] o_bin_real,
    output logic [stft_pkg::BIN_W-1:0] o_bin_imag,
    output logic                     o_last_bin
);
    localparam int NW  = $clog2(FFT_LEN);
    localparam int XW  = SAMPLE_WIDTH + 2;
    localparam int AW  = XW + 18 + NW + 1;
    localparam int STRIDE = 64 / FFT_LEN;
    localparam logic [1:0] S_IDLE = 2'd0, S_LOAD = 2'd1, S_MAC = 2'd2, S_OUT = 2'd3;

    logic [1:0]    r_state;
    logic [NW:0]   r_n;
    logic [5:0]    r_k;
    logic [NW:0]   r_mn;
    logic          r_lv, r_pv;
    logic [NW-1:0] r_li;
    stft_pkg::t_job r_job;
    logic signed [XW+17:0] r_pr, r_pim;
    logic signed [AW-1:0] r_re, r_im;
    logic signed [17:0]   r_c, r_s;
    logic [5:0]    m;
    logic signed [SAMPLE_WIDTH+17:0] prod;
    logic          r_ov;
    logic signed [XW-1:0] x_rd, x_wd;
    logic          x_we;

    assign o_job_ready  = (r_state == S_IDLE);
    assign o_loading    = (r_state == S_LOAD);
    assign o_ring_raddr = 6'(r_job.start + 6'(r_n[NW-1:0]));
    assign o_win_raddr  = 6'(r_n[NW-1:0]);
    assign prod = $signed(i_ring_rdata) * $signed({2'b00, i_win_rdata});
    assign m = 6'(r_k * 6'(r_mn[NW-1:0]) * 6'(STRIDE));

    // Saturate after floor shift
    function automatic logic [stft_pkg::BIN_W-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-16:0] s;
        s = (AW-15)'(v >>> 15);
        if (s > (AW-15)'(2097151)) return 22'h1FFFFF;
        if (s < -(AW-15)'(2097152)) return 22'h200000;
        return s[21:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_lv <= 1'b0;
            r_pv <= 1'b0;
            case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_n <= '0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // one ring/window read per cycle, product of the registered read data written back
                    if (r_n != (NW+1)'(FFT_LEN)) begin
                        r_n  <= r_n + 1'b1;
                        r_lv <= 1'b1;
                        r_li <= r_n[NW-1:0];
                    end else if (!r_lv) begin
                        r_k <= 6'd0; r_mn <= '0;
                        r_re <= '0; r_im <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_mn != (NW+1)'(FFT_LEN)) begin
                        r_c  <= stft_pkg::cos64(m);
                        r_s  <= stft_pkg::cos64(m + 6'd48);
                        r_li <= r_mn[NW-1:0];
                        r_lv <= 1'b1;
                        r_mn <= r_mn + 1'b1;
                    end else if (!r_lv && !r_pv) begin
                        r_state <= S_OUT;
                        r_ov <= 1'b1;
                    end
                    if (r_lv) begin
                        r_pr  <= x_rd * r_c;
                        r_pim <= x_rd * r_s;
                        r_pv  <= 1'b1;
                    end
                    if (r_pv) begin
                        r_re <= r_re + AW'(r_pr);
                        r_im <= r_im - AW'(r_pim);
                    end
                end
                S_OUT: if (i_res_ready) begin
                    r_ov <= 1'b0;
                    if (r_k == 6'(FFT_LEN/2)) r_state <= S_IDLE;
                    else begin
                        r_k <= r_k + 6'd1; r_mn <= '0;
                        r_re <= '0; r_im <= '0;
                        r_state <= S_MAC;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Windowed sample buffer fill (zero beyond window length), read one term per cycle
    assign x_we = (r_state == S_LOAD) && r_lv;
    assign x_wd = ((7'(r_li)) < r_job.wlen) ? XW'(prod >>> 15) : '0;

    stft_ram #(.WIDTH(XW), .DEPTH(FFT_LEN)) u_xbuf (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(r_li), .i_wdata(x_wd),
        .i_raddr(r_mn[NW-1:0]), .o_rdata(x_rd)
    );

    assign o_res_valid    = r_ov;
    assign o_frame_number = r_job.frame;
    assign o_bin_index    = r_k;
    assign o_bin_real     = sat(r_re);
    assign o_bin_imag     = sat(r_im);
    assign o_last_bin     = (r_k == 6'(FFT_LEN/2));
endmodule

// ===== rtl/stft_outq.sv =====
// Result queue: small FIFO between the engine and the pop side.
// No dependencies.
module stft_outq #(
    parameter int W = 67
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_d [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr = i_valid && o_ready;
    assign rd = i_pop && !o_empty;
    assign o_data = r_d[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) r_d[r_wp] <= i_data;
    end
endmodule

// ===== rtl/windowed_stft_stream.sv =====
// Windowed STFT stream top level. An item transfers when push is high and full is low; after
// a frame's last sample push is held off while the engine copies and windows the frame.
// The engine computes a frame's bins one at a time from bin 0 to FFT_LEN/2 and starts each
// bin after the result queue has taken the one before; a frame that closes while the engine
// is busy waits with push held off. Synchronous active-low reset clears control and framing;
// the window table is undefined until written.
module windowed_stft_stream #(
    parameter int FFT_LEN      = stft_pkg::FFT_LEN_DEF,
    parameter int SAMPLE_WIDTH = stft_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_func,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_restart,
    input  logic [5:0]              i_coef_index,
    input  logic [15:0]             i_coef_value,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [stft_pkg::CFG_W-1:0] i_cfg_data,
    output logic                    empty,
    input  logic                    pop,
    output logic [15:0]             o_frame_number,
    output logic [5:0]              o_bin_index,
    output logic [21:0]             o_bin_real,
    output logic [21:0]             o_bin_imag,
    output logic                    o_last_bin
);
    logic job_valid, job_ready, res_valid, q_ready, eng_loading;
    stft_pkg::t_job job;
    logic [5:0] ring_ra, win_ra;
    logic [SAMPLE_WIDTH-1:0] ring_rd;
    logic [15:0] win_rd;
    logic [15:0] e_frame;
    logic [5:0]  e_bin;
    logic [21:0] e_re, e_im;
    logic        e_last;

    stft_front #(.FFT_LEN(FFT_LEN), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_func, .i_sample,
        .i_restart, .i_coef_index, .i_coef_value, .i_cfg_we,
        .i_cfg_index(i_cfg_index[0]), .i_cfg_valid(1'b1), .i_cfg_data,
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready),
        .i_eng_loading(eng_loading),
        .i_ring_raddr(ring_ra), .o_ring_rdata(ring_rd),
        .i_win_raddr(win_ra), .o_win_rdata(win_rd)
    );

    stft_engine #(.FFT_LEN(FFT_LEN), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_eng (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job), .o_job_ready(job_ready),
        .o_loading(eng_loading),
        .o_ring_raddr(ring_ra), .i_ring_rdata(ring_rd),
        .o_win_raddr(win_ra), .i_win_rdata(win_rd),
        .o_res_valid(res_valid), .i_res_ready(q_ready),
        .o_frame_number(e_frame), .o_bin_index(e_bin), .o_bin_real(e_re),
        .o_bin_imag(e_im), .o_last_bin(e_last)
    );

    stft_outq #(.W(67)) u_q (
        .i_clk, .i_rst_n, .i_valid(res_valid),
        .i_data({e_frame, e_bin, e_re, e_im, e_last}), .o_ready(q_ready),
        .o_empty(empty), .i_pop(pop),
        .o_data({o_frame_number, o_bin_index, o_bin_real, o_bin_imag, o_last_bin})
    );

    // A pending job stays until the engine takes it
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && !job_ready |=> job_valid)
        else $error("frame job dropped");
    a_last_is_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last_bin |-> o_bin_index == 6'(FFT_LEN/2))
        else $error("last bin flag on wrong bin");
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_bin_index <= 6'(FFT_LEN/2))
        else $error("bin index out of range");
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for windowed_stft_stream: queue-style push/pop traffic,
// a bin-accurate transform predictor and per-field result checks.
// Depends on stft_pkg and the windowed_stft_stream RTL.
module tb_top;

    localparam int NBINS     = 33;
    localparam int WDOG_MAX  = 20000;
    localparam int LONG_HOLD = 3000;

    typedef struct {
        logic [15:0]        frame;
        logic [5:0]         bin;
        logic signed [21:0] re;
        logic signed [21:0] im;
        logic               last;
    } t_bin_result;

    typedef struct {
        logic        func;
        logic [15:0] sample;
        logic        restart;
        logic [5:0]  idx;
        logic [15:0] val;
        bit          typed;
        logic [15:0] t_frame;
        int          t_re;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_func = 1'b0;
    logic [15:0] i_sample = '0;
    logic        i_restart = 1'b0;
    logic [5:0]  i_coef_index = '0;
    logic [15:0] i_coef_value = '0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [stft_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_frame_number;
    logic [5:0]  o_bin_index;
    logic [21:0] o_bin_real;
    logic [21:0] o_bin_imag;
    logic        o_last_bin;

    windowed_stft_stream DUT (.*);

    // Clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state
    logic signed [15:0] ring [64];
    logic [15:0]        wtab [64];
    logic [31:0]        seen;
    logic [31:0]        frame_end;
    logic [15:0]        frame_cnt;
    logic [6:0]         wlen_reg;
    logic [15:0]        hop_reg;

    t_bin_result expected_bins[$];
    int errors = 0;
    int n_checked = 0;
    bit no_idle = 1'b0;
    int long_hold = 0;
    bit hold_done = 1'b0;

    const int qcos[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                           20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    function automatic int tw_cos(int m);
        m = m & 63;
        if (m <= 16) return qcos[m];
        if (m <= 32) return -qcos[32 - m];
        if (m <= 48) return -qcos[m - 32];
        return qcos[64 - m];
    endfunction

    function automatic int eff_wlen();
        if (wlen_reg == 0) return 1;
        if (wlen_reg > 64) return 64;
        return int'(wlen_reg);
    endfunction

    function automatic void rearm_framing();
        seen      = '0;
        frame_end = 32'(eff_wlen() - 1);
        frame_cnt = '0;
    endfunction

    function automatic logic signed [21:0] sat22(longint v);
        if (v > 64'sd2097151) v = 64'sd2097151;
        if (v < -64'sd2097152) v = -64'sd2097152;
        return v[21:0];
    endfunction

    // Predict the bins caused by one accepted item
    function automatic void predict_item(t_row r);
        longint x [64];
        longint re, im;
        int wl;
        logic [31:0] start;
        t_bin_result b;
        if (r.func) begin
            wtab[r.idx] = r.val;
            return;
        end
        if (r.restart) rearm_framing();
        ring[seen[5:0]] = r.sample;
        if (seen != frame_end) begin
            seen++;
            return;
        end
        wl = eff_wlen();
        start = seen - 32'(wl - 1);
        for (int n = 0; n < 64; n++) begin
            if (n < wl)
                x[n] = (longint'(ring[(start + 32'(n)) & 32'd63]) *
                        longint'({1'b0, wtab[n]})) >>> 15;
            else
                x[n] = 0;
        end
        for (int k = 0; k < NBINS; k++) begin
            re = 0;
            im = 0;
            for (int n = 0; n < 64; n++) begin
                re += x[n] * longint'(tw_cos(k * n));
                im -= x[n] * longint'(tw_cos(k * n + 48));
            end
            b.frame = frame_cnt;
            b.bin   = 6'(k);
            b.re    = sat22(re >>> 15);
            b.im    = sat22(im >>> 15);
            b.last  = (k == NBINS - 1);
            if (r.typed) begin
                b.frame = r.t_frame;
                b.re    = 22'(r.t_re);
                b.im    = '0;
            end
            expected_bins.push_back(b);
        end
        frame_end += (hop_reg == 0) ? 32'd1 : 32'(hop_reg);
        frame_cnt++;
        seen++;
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(3, 0) != 0) return 0;
        return $urandom_range(10, 1);
    endfunction

    // Offer one item; called at a falling edge, returns at a falling edge
    task automatic send_item(t_row r);
        int g;
        push         <= 1'b1;
        i_func       <= r.func;
        i_sample     <= r.sample;
        i_restart    <= r.restart;
        i_coef_index <= r.idx;
        i_coef_value <= r.val;
        do @(posedge i_clk); while (full);
        predict_item(r);
        @(negedge i_clk);
        g = pick_gap();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic send_sample(logic [15:0] s, logic rs);
        t_row r;
        r = '{1'b0, s, rs, 6'($urandom), 16'($urandom), 1'b0, 16'd0, 0};
        send_item(r);
    endtask

    task automatic send_coef(logic [5:0] ix, logic [15:0] v);
        t_row r;
        r = '{1'b1, 16'($urandom), 1'($urandom), ix, v, 1'b0, 16'd0, 0};
        send_item(r);
    endtask

    // Register write once all results are out and the engine has drained
    task automatic write_reg(logic [0:0] ix, logic [15:0] d);
        push <= 1'b0;
        while (expected_bins.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (ix == stft_pkg::CFG_WLEN) wlen_reg = d[6:0];
        else hop_reg = d;
        rearm_framing();
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7, 0))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random stream of one phase: mostly samples with some restarts, and some coefficient writes when coef_mix is set
    task automatic random_phase(int n_items, bit coef_mix);
        for (int i = 0; i < n_items; i++) begin
            if (coef_mix && $urandom_range(9, 0) == 0)
                send_coef(6'($urandom), 16'($urandom));
            else
                send_sample(rand_sample(), $urandom_range(29, 0) == 0);
        end
    endtask

    // Result side: check at the rising edge, choose pop at the falling edge
    int rx_burst = 0;
    initial begin
        t_bin_result e;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (expected_bins.size() == 0) begin
                    $error("unexpected result bin %0d frame %0d", o_bin_index, o_frame_number);
                    errors++;
                end else begin
                    e = expected_bins.pop_front();
                    if (o_frame_number !== e.frame) begin
                        $error("frame_number exp %0d got %0d", e.frame, o_frame_number);
                        errors++;
                    end
                    if (o_bin_index !== e.bin) begin
                        $error("bin_index exp %0d got %0d", e.bin, o_bin_index);
                        errors++;
                    end
                    if (o_bin_real !== e.re) begin
                        $error("bin_real exp %0d got %0d", e.re, $signed(o_bin_real));
                        errors++;
                    end
                    if (o_bin_imag !== e.im) begin
                        $error("bin_imag exp %0d got %0d", e.im, $signed(o_bin_imag));
                        errors++;
                    end
                    if (o_last_bin !== e.last) begin
                        $error("last_bin exp %0d got %0d", e.last, o_last_bin);
                        errors++;
                    end
                end
                n_checked++;
                if (n_checked == 40 && !hold_done) begin
                    long_hold = LONG_HOLD;
                    hold_done = 1'b1;
                end
            end
            @(negedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                pop <= 1'b0;
            end else if (rx_burst > 0) begin
                rx_burst--;
                pop <= 1'b0;
            end else if (!no_idle && $urandom_range(4, 0) == 0) begin
                rx_burst = $urandom_range(10, 1) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet = 0;
        else quiet++;
        if (quiet >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Directed rows: window length 1, hop 1, so every sample closes a frame
    t_row directed[14] = '{
        '{1'b1, 16'h0000, 1'b0, 6'd0, 16'd32768, 1'b0, 16'd0, 0},
        '{1'b0, 16'h7FFF, 1'b0, 6'd0, 16'd0, 1'b1, 16'd0, 32767},
        '{1'b0, 16'h8000, 1'b0, 6'd0, 16'd0, 1'b1, 16'd1, -32768},
        '{1'b0, 16'h0000, 1'b0, 6'd0, 16'd0, 1'b1, 16'd2, 0},
        '{1'b0, 16'hFFFF, 1'b0, 6'd0, 16'd0, 1'b1, 16'd3, -1},
        '{1'b0, 16'h0001, 1'b1, 6'd0, 16'd0, 1'b1, 16'd0, 1},
        '{1'b1, 16'h1234, 1'b1, 6'd0, 16'hFFFF, 1'b0, 16'd0, 0},
        '{1'b0, 16'd20000, 1'b0, 6'd0, 16'd0, 1'b0, 16'd0, 0},
        '{1'b0, 16'h8000, 1'b0, 6'd0, 16'd0, 1'b0, 16'd0, 0},
        '{1'b1, 16'h0000, 1'b0, 6'd0, 16'd0, 1'b0, 16'd0, 0},
        '{1'b0, 16'd12345, 1'b0, 6'd0, 16'd0, 1'b1, 16'd3, 0},
        '{1'b1, 16'h0000, 1'b0, 6'd0, 16'd32768, 1'b0, 16'd0, 0},
        '{1'b0, 16'h5555, 1'b0, 6'd0, 16'd0, 1'b1, 16'd4, 21845},
        '{1'b0, 16'hAAAA, 1'b0, 6'd0, 16'd0, 1'b1, 16'd5, -21846}
    };

    // Main sequence
    initial begin
        for (int i = 0; i < 64; i++) begin
            ring[i] = '0;
            wtab[i] = '0;
        end
        wlen_reg = 7'(stft_pkg::WLEN_RESET);
        hop_reg  = 16'(stft_pkg::HOP_RESET);
        rearm_framing();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Load the whole window table before any frame closes
        for (int i = 0; i < 64; i++) send_coef(6'(i), 16'($urandom_range(32768, 0)));
        // Reset framing: 64-sample frames every 16 samples
        random_phase(100, 1'b0);

        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd1});
        write_reg(stft_pkg::CFG_HOP, 16'd1);
        foreach (directed[i]) send_item(directed[i]);

        // Zero length and zero hop behave as one
        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd0});
        write_reg(stft_pkg::CFG_HOP, 16'd0);
        random_phase(10, 1'b1);

        // Length above the transform size clamps to 64; longest hop
        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd100});
        write_reg(stft_pkg::CFG_HOP, 16'hFFFF);
        random_phase(70, 1'b0);

        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd17});
        write_reg(stft_pkg::CFG_HOP, 16'd9);
        random_phase(30, 1'b1);

        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd33});
        write_reg(stft_pkg::CFG_HOP, 16'd20);
        random_phase(45, 1'b1);

        // Saturation: oversized coefficients with full-scale constant input
        for (int i = 0; i < 33; i++) send_coef(6'(i), 16'hFFFF);
        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd33});
        write_reg(stft_pkg::CFG_HOP, 16'd33);
        for (int i = 0; i < 33; i++) send_sample(16'h7FFF, 1'b0);
        for (int i = 0; i < 33; i++) send_sample(16'h8000, 1'b0);

        // Final stretch without idling
        for (int i = 0; i < 8; i++) send_coef(6'(i), 16'($urandom));
        write_reg(stft_pkg::CFG_WLEN, {9'($urandom), 7'd8});
        write_reg(stft_pkg::CFG_HOP, 16'd12);
        no_idle = 1'b1;
        random_phase(24, 1'b0);
        push <= 1'b0;

        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_bins.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
